[rtl/core/ealu_pkg.sv]
// Shared types, operation codes and decimal-adjust constants for the eight-bit ALU.
package ealu_pkg;

   // Operation codes. Codes 19 to 31 are unused and leave the left value and flags unchanged.
   localparam logic [4:0] KIND_ADC    = 5'd0;
   localparam logic [4:0] KIND_SBC    = 5'd1;
   localparam logic [4:0] KIND_AND    = 5'd2;
   localparam logic [4:0] KIND_OR     = 5'd3;
   localparam logic [4:0] KIND_XOR    = 5'd4;
   localparam logic [4:0] KIND_CMP    = 5'd5;
   localparam logic [4:0] KIND_BIT    = 5'd6;
   localparam logic [4:0] KIND_ASL    = 5'd7;
   localparam logic [4:0] KIND_LSR    = 5'd8;
   localparam logic [4:0] KIND_ROL    = 5'd9;
   localparam logic [4:0] KIND_ROR    = 5'd10;
   localparam logic [4:0] KIND_INC    = 5'd11;
   localparam logic [4:0] KIND_DEC    = 5'd12;
   localparam logic [4:0] KIND_COM    = 5'd13;
   localparam logic [4:0] KIND_SWAP   = 5'd14;
   localparam logic [4:0] KIND_TST    = 5'd15;
   localparam logic [4:0] KIND_SETBIT = 5'd16;
   localparam logic [4:0] KIND_CLRBIT = 5'd17;
   localparam logic [4:0] KIND_LOAD   = 5'd18;

   // Decimal adjust constants, sized for the ten-bit adder used by decimal addition.
   localparam logic [9:0] DIG_LIMIT_LO = 10'h00a;
   localparam logic [9:0] DIG_ADJ_LO   = 10'h006;
   localparam logic [9:0] DIG_LIMIT_HI = 10'h0a0;
   localparam logic [9:0] DIG_ADJ_HI   = 10'h060;
   localparam logic [9:0] DIG_CARRY_LO = 10'h010;
   localparam logic [9:0] DIG_CARRY_HI = 10'h100;

   typedef struct packed {
      logic negative;
      logic overflow;
      logic zero;
      logic carry;
   } flags_type;

   typedef struct packed {
      logic [4:0] kind;
      logic [7:0] left;
      logic [7:0] operand;
      logic [2:0] bit_index;
      flags_type  flags;
      logic       decimal_mode;
   } op_type;

   typedef struct packed {
      logic [7:0] result;
      flags_type  flags;
   } res_type;

endpackage

[rtl/core/ealu_if.sv]
// Valid/ready channel interfaces for the ALU operation and result transactions.
interface ealu_req_if;
   logic       valid;
   logic       ready;
   logic [4:0] kind;
   logic [7:0] left;
   logic [7:0] operand;
   logic [2:0] bit_index;
   logic       carry_in;
   logic       overflow_in;
   logic       negative_in;
   logic       zero_in;
   logic       decimal_mode;

   modport source (
      output valid, kind, left, operand, bit_index, carry_in, overflow_in, negative_in,
             zero_in, decimal_mode,
      input  ready
   );
   modport sink (
      input  valid, kind, left, operand, bit_index, carry_in, overflow_in, negative_in,
             zero_in, decimal_mode,
      output ready
   );
endinterface

interface ealu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] result;
   logic       negative;
   logic       overflow;
   logic       zero;
   logic       carry;

   modport source (
      output valid, result, negative, overflow, zero, carry,
      input  ready
   );
   modport sink (
      input  valid, result, negative, overflow, zero, carry,
      output ready
   );
endinterface

[rtl/core/ealu_exec.sv]
// Combinational execute logic: binary and decimal arithmetic, logic, shifts and bit operations.
module ealu_exec (
   input  ealu_pkg::op_type  op,
   output ealu_pkg::res_type res
);
   import ealu_pkg::*;

   logic [8:0]  bin_sum;
   logic [7:0]  inv_operand;
   logic [9:0]  add_acc;
   logic        add_v;
   logic [10:0] sub_acc;
   logic        sub_lo_borrow;
   logic        sub_hi_borrow;
   logic [7:0]  sub_bin;
   logic        sub_v;
   logic [8:0]  cmp_diff;
   logic [7:0]  bit_mask;
   logic [7:0]  nz_value;
   logic        set_nz;
   logic [7:0]  result;
   flags_type   flags;

   // Decimal addition, one digit at a time with the carry folded into the adjust.
   always_comb begin
      add_acc = {9'd0, op.flags.carry} + {6'd0, op.left[3:0]} + {6'd0, op.operand[3:0]};
      if (add_acc >= DIG_LIMIT_LO) begin
         add_acc = ((add_acc + DIG_ADJ_LO) & (DIG_CARRY_LO - 10'd1)) + DIG_CARRY_LO;
      end
      add_acc = add_acc + {2'd0, op.left[7:4], 4'd0} + {2'd0, op.operand[7:4], 4'd0};
      // Overflow is taken from the partial sum before the high digit is adjusted.
      add_v = (add_acc[7] ^ op.left[7]) & (add_acc[7] ^ op.operand[7]);
      if (add_acc >= DIG_LIMIT_HI) begin
         add_acc = ((add_acc + DIG_ADJ_HI) & (DIG_CARRY_HI - 10'd1)) + DIG_CARRY_HI;
      end
   end

   // Decimal subtraction. A wrapped negative difference compares above any digit limit,
   // so an unsigned comparison covers both the borrow and the out-of-range cases.
   always_comb begin
      sub_bin = op.left - op.operand - {7'd0, ~op.flags.carry};
      sub_v   = (sub_bin[7] ^ op.left[7]) & (~sub_bin[7] ^ op.operand[7]);
      sub_acc = {7'd0, op.left[3:0]} - {7'd0, op.operand[3:0]} - {10'd0, ~op.flags.carry};
      if (sub_acc > 11'h00f) begin
         sub_acc = sub_acc - {1'b0, DIG_ADJ_LO};
      end
      sub_lo_borrow = sub_acc > 11'h00f;
      sub_acc = {7'd0, sub_acc[3:0]} + {3'd0, op.left[7:4], 4'd0}
              - {3'd0, op.operand[7:4], 4'd0}
              - (sub_lo_borrow ? {1'b0, DIG_CARRY_LO} : 11'd0);
      if (sub_acc > 11'h0f0) begin
         sub_acc = sub_acc - {1'b0, DIG_ADJ_HI};
      end
      sub_hi_borrow = sub_acc > 11'h0f0;
   end

   always_comb begin
      inv_operand = ~op.operand;
      bin_sum     = 9'd0;
      cmp_diff    = {1'b0, op.left} - {1'b0, op.operand};
      bit_mask    = 8'd1 << op.bit_index;
      result      = op.left;
      flags       = op.flags;
      nz_value    = 8'd0;
      set_nz      = 1'b0;

      unique case (op.kind)
         KIND_ADC: begin
            if (op.decimal_mode) begin
               result         = add_acc[7:0];
               flags.overflow = add_v;
               flags.carry    = add_acc[8];
            end else begin
               bin_sum        = {1'b0, op.left} + {1'b0, op.operand} + {8'd0, op.flags.carry};
               result         = bin_sum[7:0];
               flags.overflow = (bin_sum[7] ^ op.left[7]) & (bin_sum[7] ^ op.operand[7]);
               flags.carry    = bin_sum[8];
            end
            nz_value = result;
            set_nz   = 1'b1;
         end
         KIND_SBC: begin
            if (op.decimal_mode) begin
               result         = sub_acc[7:0];
               flags.overflow = sub_v;
               flags.carry    = ~sub_hi_borrow;
            end else begin
               bin_sum        = {1'b0, op.left} + {1'b0, inv_operand} + {8'd0, op.flags.carry};
               result         = bin_sum[7:0];
               flags.overflow = (bin_sum[7] ^ op.left[7]) & (bin_sum[7] ^ inv_operand[7]);
               flags.carry    = bin_sum[8];
            end
            nz_value = result;
            set_nz   = 1'b1;
         end
         KIND_AND: begin
            result   = op.left & op.operand;
            nz_value = result;
            set_nz   = 1'b1;
         end
         KIND_OR: begin
            result   = op.left | op.operand;
            nz_value = result;
            set_nz   = 1'b1;
         end
         KIND_XOR: begin
            result   = op.left ^ op.operand;
            nz_value = result;
            set_nz   = 1'b1;
         end
         KIND_CMP: begin
            flags.carry = ~cmp_diff[8];
            nz_value    = cmp_diff[7:0];
            set_nz      = 1'b1;
         end
         KIND_BIT: begin
            flags.zero     = (op.left & op.operand) == 8'd0;
            flags.negative = op.operand[7];
            flags.overflow = op.operand[6];
         end
         KIND_ASL: begin
            flags.carry = op.operand[7];
            result      = {op.operand[6:0], 1'b0};
            nz_value    = result;
            set_nz      = 1'b1;
         end
         KIND_LSR: begin
            flags.carry = op.operand[0];
            result      = {1'b0, op.operand[7:1]};
            nz_value    = result;
            set_nz      = 1'b1;
         end
         KIND_ROL: begin
            result      = {op.operand[6:0], op.flags.carry};
            flags.carry = op.operand[7];
            nz_value    = result;
            set_nz      = 1'b1;
         end
         KIND_ROR: begin
            result      = {op.flags.carry, op.operand[7:1]};
            flags.carry = op.operand[0];
            nz_value    = result;
            set_nz      = 1'b1;
         end
         KIND_INC: begin
            result   = op.operand + 8'd1;
            nz_value = result;
            set_nz   = 1'b1;
         end
         KIND_DEC: begin
            result   = op.operand - 8'd1;
            nz_value = result;
            set_nz   = 1'b1;
         end
         KIND_COM: begin
            result   = inv_operand;
            nz_value = result;
            set_nz   = 1'b1;
         end
         KIND_SWAP: begin
            result = {op.operand[3:0], op.operand[7:4]};
         end
         KIND_TST: begin
            nz_value = op.operand;
            set_nz   = 1'b1;
         end
         KIND_SETBIT: begin
            result = op.operand | bit_mask;
         end
         KIND_CLRBIT: begin
            result = op.operand & ~bit_mask;
         end
         KIND_LOAD: begin
            result   = op.operand;
            nz_value = result;
            set_nz   = 1'b1;
         end
         default: begin
            result = op.left;
         end
      endcase

      if (set_nz) begin
         flags.negative = nz_value[7];
         flags.zero     = nz_value == 8'd0;
      end

      res.result = result;
      res.flags  = flags;
   end

endmodule

[rtl/core/eight_bit_cpu_alu_with_bcd.sv]
// Top level of the eight-bit ALU: operand register, execute logic and result register.
//
//   Channel  Direction  Handshake        Payload
//   req      in         req.valid/ready  kind, left, operand, bit_index, flags in, decimal_mode
//   rsp      out        rsp.valid/ready  result, negative, overflow, zero, carry
//
// One transaction is accepted in every cycle while the result side keeps taking results.
// A transaction accepted on req is captured in the operand register, passes through the
// execute logic and lands in the result register, from which its result is offered on rsp.
// The single pass through the execute logic sets the rate.
// Reset is synchronous and empties both registers. When rsp stalls, the result register holds
// and the operand register keeps one further transaction, after which req.ready falls.
module eight_bit_cpu_alu_with_bcd (
   input  logic        clock,
   input  logic        reset,
   ealu_req_if.sink    req,
   ealu_rsp_if.source  rsp
);
   import ealu_pkg::*;

   // Operand register: holds one accepted transaction for the execute logic.
   logic    op_valid_ff;
   logic    op_valid_in;
   op_type  op_data_ff;
   op_type  op_data_in;

   // Result register: holds the finished result until the consumer takes it.
   logic    res_valid_ff;
   logic    res_valid_in;
   res_type res_data_ff;
   res_type res_data_in;

   res_type exec_res;

   logic    res_free;
   logic    op_free;
   logic    req_take;
   logic    op_move;

   ealu_exec u_exec (
      .op  (op_data_ff),
      .res (exec_res)
   );

   // The result register can load when empty or when its content leaves this cycle; the
   // operand register can load when empty or when its content moves on.
   assign res_free = ~res_valid_ff | rsp.ready;
   assign op_free  = ~op_valid_ff | res_free;
   assign op_move  = op_valid_ff & res_free;
   assign req_take = req.valid & op_free;

   assign req.ready = op_free;

   always_comb begin
      op_valid_in = op_valid_ff;
      op_data_in  = op_data_ff;
      if (op_free) begin
         op_valid_in = req.valid;
      end
      if (req_take) begin
         op_data_in.kind           = req.kind;
         op_data_in.left           = req.left;
         op_data_in.operand        = req.operand;
         op_data_in.bit_index      = req.bit_index;
         op_data_in.flags.negative = req.negative_in;
         op_data_in.flags.overflow = req.overflow_in;
         op_data_in.flags.zero     = req.zero_in;
         op_data_in.flags.carry    = req.carry_in;
         op_data_in.decimal_mode   = req.decimal_mode;
      end

      res_valid_in = res_valid_ff;
      res_data_in  = res_data_ff;
      if (res_free) begin
         res_valid_in = op_valid_ff;
      end
      if (op_move) begin
         res_data_in = exec_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_valid_ff  <= 1'b0;
         res_valid_ff <= 1'b0;
      end else begin
         op_valid_ff  <= op_valid_in;
         res_valid_ff <= res_valid_in;
      end
      op_data_ff  <= op_data_in;
      res_data_ff <= res_data_in;
   end

   assign rsp.valid    = res_valid_ff;
   assign rsp.result   = res_data_ff.result;
   assign rsp.negative = res_data_ff.flags.negative;
   assign rsp.overflow = res_data_ff.flags.overflow;
   assign rsp.zero     = res_data_ff.flags.zero;
   assign rsp.carry    = res_data_ff.flags.carry;

endmodule

[dv/eight_bit_cpu_alu_with_bcd_test.sv]
// Self-checking testbench for the eight-bit ALU: directed table, random operations, stall phases.
module eight_bit_cpu_alu_with_bcd_test;
   timeunit 1ns;
   timeprecision 1ps;

   import ealu_pkg::*;

   // Operation codes beyond the last defined one; the block must leave left and flags alone.
   localparam logic [4:0] KIND_UNUSED_FIRST = 5'd19;
   localparam logic [4:0] KIND_UNUSED_LAST  = 5'd31;

   localparam int RESET_CYCLES     = 10;
   localparam int ITEMS_PER_PHASE  = 320;
   localparam int BACKLOG_HOLD     = 64;
   localparam int DRAIN_CYCLES     = 8;
   localparam int CYCLE_LIMIT      = 200000;

   // Traffic phases. In the backlog phase the receiver refuses results for a long stretch
   // while the sender keeps offering, so that both internal registers fill and req.ready drops.
   typedef enum int {
      PH_STEADY,
      PH_BACKLOG,
      PH_SENDER_GAPS,
      PH_RECEIVER_STALLS,
      PH_BOTH_IDLE,
      PH_COUNT
   } traffic_phase_type;

   localparam int SENDER_IDLE_PCT[PH_COUNT]   = '{0, 0, 70, 0, 8};
   localparam int RECEIVER_STALL_PCT[PH_COUNT] = '{0, 0, 0, 70, 8};

   typedef struct {
      op_type  op;
      bit      typed;
      res_type want;
   } vector_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ealu_req_if req_ch();
   ealu_rsp_if rsp_ch();

   eight_bit_cpu_alu_with_bcd u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   traffic_phase_type phase = PH_STEADY;
   res_type           pending_outcomes[$];
   vector_row_type    directed_vectors[$];
   int                mismatches   = 0;
   int                cycle_count  = 0;
   bit                backlog_held = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // The flag arguments are packed as {negative, overflow, zero, carry}, matching flags_type.
   function automatic op_type mk_op(logic [4:0] kind, logic [7:0] left, logic [7:0] operand,
                                    logic [2:0] bit_index, logic [3:0] nvzc, logic decimal);
      op_type op;
      op.kind         = kind;
      op.left         = left;
      op.operand      = operand;
      op.bit_index    = bit_index;
      op.flags        = flags_type'(nvzc);
      op.decimal_mode = decimal;
      return op;
   endfunction

   function automatic res_type mk_res(logic [7:0] result, logic [3:0] nvzc);
      res_type res;
      res.result = result;
      res.flags  = flags_type'(nvzc);
      return res;
   endfunction

   // Independent model of the execute logic. Arithmetic is done in 32-bit unsigned integers,
   // so that the wrap-around of the nibble-wise decimal subtract behaves as the block's does.
   function automatic res_type alu_outcome(op_type op);
      int unsigned a, b, c, v, n, z, r, nz, s, part, borrow, diff, nb;
      bit          nz_update;
      res_type     res;
      a = op.left;
      b = op.operand;
      c = op.flags.carry;
      v = op.flags.overflow;
      n = op.flags.negative;
      z = op.flags.zero;
      r = a;
      nz = 0;
      nz_update = 1'b0;
      case (op.kind)
         KIND_ADC: begin
            if (op.decimal_mode) begin
               // Low digit first, then the high digit; V comes from the sum before the
               // high digit is adjusted.
               s = c + (a & 'h0f) + (b & 'h0f);
               part = s & 'h0f;
               if (s >= 'h0a) s = ((s + 'h06) & 'h0f) + 'h10;
               s = s + (a & 'hf0) + (b & 'hf0);
               part = part + (s & 'hf0);
               if (s >= 'ha0) s = ((s + 'h60) & 'hff) + 'h100;
               v = (((part ^ a) & (part ^ b)) >> 7) & 1;
            end else begin
               s = a + b + c;
               v = (((s ^ a) & (s ^ b)) >> 7) & 1;
            end
            r = s & 'hff;
            c = (s >> 8) & 1;
            nz = r;
            nz_update = 1'b1;
         end
         KIND_SBC: begin
            if (op.decimal_mode) begin
               // V is taken from the plain binary difference, not the adjusted one.
               borrow = c ^ 1;
               diff = (a - b - borrow) & 'hffff;
               s = (a & 'h0f) - (b & 'h0f) - borrow;
               if (s > 'h0f) s = s - 'h06;
               borrow = (s > 'h0f) ? 'h10 : 0;
               s = s & 'h0f;
               s = s + (a & 'hf0) - (b & 'hf0) - borrow;
               if (s > 'hf0) s = s - 'h60;
               borrow = (s > 'hf0) ? 'h100 : 0;
               r = s & 'hff;
               v = (((diff ^ a) & (~diff ^ b)) >> 7) & 1;
               c = ((borrow >> 8) & 1) ^ 1;
            end else begin
               nb = ~b & 'hff;
               s = a + nb + c;
               v = (((s ^ a) & (s ^ nb)) >> 7) & 1;
               r = s & 'hff;
               c = (s >> 8) & 1;
            end
            nz = r;
            nz_update = 1'b1;
         end
         KIND_AND: begin r = a & b; nz = r; nz_update = 1'b1; end
         KIND_OR:  begin r = a | b; nz = r; nz_update = 1'b1; end
         KIND_XOR: begin r = a ^ b; nz = r; nz_update = 1'b1; end
         KIND_CMP: begin
            diff = (a - b) & 'hffff;
            c = ((~diff) >> 8) & 1;
            nz = diff & 'hff;
            nz_update = 1'b1;
         end
         KIND_BIT: begin
            z = ((a & b) == 0) ? 1 : 0;
            n = (b >> 7) & 1;
            v = (b >> 6) & 1;
         end
         KIND_ASL: begin c = (b >> 7) & 1; r = (b << 1) & 'hff; nz = r; nz_update = 1'b1; end
         KIND_LSR: begin c = b & 1; r = b >> 1; nz = r; nz_update = 1'b1; end
         KIND_ROL: begin
            r = ((b << 1) | c) & 'hff;
            c = (b >> 7) & 1;
            nz = r;
            nz_update = 1'b1;
         end
         KIND_ROR: begin
            r = (b >> 1) | (c << 7);
            c = b & 1;
            nz = r;
            nz_update = 1'b1;
         end
         KIND_INC:    begin r = (b + 1) & 'hff; nz = r; nz_update = 1'b1; end
         KIND_DEC:    begin r = (b - 1) & 'hff; nz = r; nz_update = 1'b1; end
         KIND_COM:    begin r = ~b & 'hff; nz = r; nz_update = 1'b1; end
         KIND_SWAP:   r = ((b >> 4) | (b << 4)) & 'hff;
         KIND_TST:    begin nz = b; nz_update = 1'b1; end
         KIND_SETBIT: r = b | (1 << op.bit_index);
         KIND_CLRBIT: r = b & ~(1 << op.bit_index) & 'hff;
         KIND_LOAD:   begin r = b; nz = r; nz_update = 1'b1; end
         default:     r = a;
      endcase
      if (nz_update) begin
         n = (nz >> 7) & 1;
         z = (nz == 0) ? 1 : 0;
      end
      res.result         = r[7:0];
      res.flags.negative = n[0];
      res.flags.overflow = v[0];
      res.flags.zero     = z[0];
      res.flags.carry    = c[0];
      return res;
   endfunction

   // Bytes lean towards the values where carries, signs and zero results change.
   function automatic logic [7:0] pick_byte();
      logic [7:0] corners[5];
      corners = '{8'h00, 8'h01, 8'h7f, 8'h80, 8'hff};
      if ($urandom_range(0, 7) == 0) return corners[$urandom_range(0, 4)];
      return 8'($urandom);
   endfunction

   function automatic op_type random_op();
      op_type op;
      op.kind = ($urandom_range(0, 15) == 0) ?
                5'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST)) :
                5'($urandom_range(KIND_ADC, KIND_LOAD));
      // Add and subtract carry the most logic, so they get an extra share.
      if ($urandom_range(0, 3) == 0) op.kind = $urandom_range(0, 1) ? KIND_ADC : KIND_SBC;
      op.left         = pick_byte();
      op.operand      = pick_byte();
      op.bit_index    = 3'($urandom_range(0, 7));
      op.flags        = flags_type'(4'($urandom_range(0, 15)));
      op.decimal_mode = 1'($urandom_range(0, 1));
      // Most decimal arithmetic uses proper BCD digits; the rest keeps raw bytes.
      if (op.decimal_mode && (op.kind == KIND_ADC || op.kind == KIND_SBC) &&
          $urandom_range(0, 3) != 0) begin
         op.left    = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
         op.operand = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
      end
      return op;
   endfunction

   // Offers one transaction, starting at a falling edge, and returns at the rising edge that
   // accepts it. Idle cycles before the offer follow the current phase. The valid line is only
   // lowered when an idle cycle is really taken, so back-to-back offers keep it high.
   task automatic offer(op_type op, res_type want);
      @(negedge clock);
      while ($urandom_range(0, 99) < SENDER_IDLE_PCT[phase]) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.kind         <= op.kind;
      req_ch.left         <= op.left;
      req_ch.operand      <= op.operand;
      req_ch.bit_index    <= op.bit_index;
      req_ch.carry_in     <= op.flags.carry;
      req_ch.overflow_in  <= op.flags.overflow;
      req_ch.negative_in  <= op.flags.negative;
      req_ch.zero_in      <= op.flags.zero;
      req_ch.decimal_mode <= op.decimal_mode;
      req_ch.valid        <= 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      pending_outcomes.push_back(want);
   endtask

   task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endtask

   // Stimulus: reset, the directed table, then random traffic phase by phase.
   initial begin
      req_ch.valid        = 1'b0;
      req_ch.kind         = '0;
      req_ch.left         = '0;
      req_ch.operand      = '0;
      req_ch.bit_index    = '0;
      req_ch.carry_in     = 1'b0;
      req_ch.overflow_in  = 1'b0;
      req_ch.negative_in  = 1'b0;
      req_ch.zero_in      = 1'b0;
      req_ch.decimal_mode = 1'b0;

      // Rows with a typed result are simple enough to work out by hand; the decimal rows,
      // including the ones with digits above nine, rely on the predictor.
      directed_vectors = '{
         '{mk_op(KIND_ADC, 8'hff, 8'h01, 3'd0, 4'b0000, 1'b0), 1'b1, mk_res(8'h00, 4'b0011)},
         '{mk_op(KIND_ADC, 8'h7f, 8'h01, 3'd0, 4'b0000, 1'b0), 1'b1, mk_res(8'h80, 4'b1100)},
         '{mk_op(KIND_SBC, 8'h00, 8'h01, 3'd0, 4'b0001, 1'b0), 1'b1, mk_res(8'hff, 4'b1000)},
         '{mk_op(KIND_SBC, 8'h80, 8'h01, 3'd0, 4'b0001, 1'b0), 1'b1, mk_res(8'h7f, 4'b0101)},
         '{mk_op(KIND_ADC, 8'h99, 8'h01, 3'd0, 4'b0000, 1'b1), 1'b0, '0},
         '{mk_op(KIND_ADC, 8'h58, 8'h46, 3'd0, 4'b0001, 1'b1), 1'b0, '0},
         '{mk_op(KIND_SBC, 8'h00, 8'h01, 3'd0, 4'b0001, 1'b1), 1'b0, '0},
         '{mk_op(KIND_SBC, 8'h46, 8'h12, 3'd0, 4'b0000, 1'b1), 1'b0, '0},
         '{mk_op(KIND_ADC, 8'hff, 8'hff, 3'd0, 4'b0001, 1'b1), 1'b0, '0},
         '{mk_op(KIND_SBC, 8'h0f, 8'hfa, 3'd0, 4'b0000, 1'b1), 1'b0, '0},
         '{mk_op(KIND_AND, 8'hff, 8'h00, 3'd0, 4'b1111, 1'b0), 1'b1, mk_res(8'h00, 4'b0111)},
         '{mk_op(KIND_OR,  8'h80, 8'h01, 3'd0, 4'b0000, 1'b0), 1'b1, mk_res(8'h81, 4'b1000)},
         '{mk_op(KIND_XOR, 8'hff, 8'hff, 3'd0, 4'b1101, 1'b0), 1'b1, mk_res(8'h00, 4'b0111)},
         '{mk_op(KIND_CMP, 8'h10, 8'h20, 3'd0, 4'b0000, 1'b0), 1'b1, mk_res(8'h10, 4'b1000)},
         '{mk_op(KIND_CMP, 8'hff, 8'hff, 3'd0, 4'b0100, 1'b0), 1'b1, mk_res(8'hff, 4'b0111)},
         '{mk_op(KIND_BIT, 8'h0f, 8'hc0, 3'd0, 4'b0001, 1'b0), 1'b1, mk_res(8'h0f, 4'b1111)},
         '{mk_op(KIND_ASL, 8'h00, 8'h80, 3'd0, 4'b0000, 1'b0), 1'b1, mk_res(8'h00, 4'b0011)},
         '{mk_op(KIND_LSR, 8'h00, 8'h01, 3'd0, 4'b0000, 1'b0), 1'b1, mk_res(8'h00, 4'b0011)},
         '{mk_op(KIND_ROL, 8'h00, 8'h80, 3'd0, 4'b0001, 1'b0), 1'b1, mk_res(8'h01, 4'b0001)},
         '{mk_op(KIND_ROR, 8'h00, 8'h01, 3'd0, 4'b0001, 1'b0), 1'b1, mk_res(8'h80, 4'b1001)},
         '{mk_op(KIND_INC, 8'h00, 8'hff, 3'd0, 4'b0000, 1'b0), 1'b1, mk_res(8'h00, 4'b0010)},
         '{mk_op(KIND_DEC, 8'h00, 8'h00, 3'd0, 4'b0000, 1'b0), 1'b1, mk_res(8'hff, 4'b1000)},
         '{mk_op(KIND_COM, 8'h00, 8'h00, 3'd0, 4'b0000, 1'b0), 1'b1, mk_res(8'hff, 4'b1000)},
         '{mk_op(KIND_SWAP, 8'h00, 8'ha5, 3'd0, 4'b1010, 1'b0), 1'b1, mk_res(8'h5a, 4'b1010)},
         '{mk_op(KIND_TST, 8'h33, 8'h00, 3'd0, 4'b1000, 1'b0), 1'b1, mk_res(8'h33, 4'b0010)},
         '{mk_op(KIND_SETBIT, 8'h00, 8'h00, 3'd7, 4'b0101, 1'b0), 1'b1,
           mk_res(8'h80, 4'b0101)},
         '{mk_op(KIND_CLRBIT, 8'h00, 8'hff, 3'd0, 4'b0000, 1'b0), 1'b1,
           mk_res(8'hfe, 4'b0000)},
         '{mk_op(KIND_LOAD, 8'h00, 8'h80, 3'd0, 4'b0000, 1'b0), 1'b1, mk_res(8'h80, 4'b1000)},
         '{mk_op(KIND_UNUSED_FIRST, 8'ha5, 8'h3c, 3'd2, 4'b0101, 1'b1), 1'b1,
           mk_res(8'ha5, 4'b0101)},
         '{mk_op(KIND_UNUSED_LAST, 8'h5a, 8'hc3, 3'd5, 4'b1010, 1'b0), 1'b1,
           mk_res(8'h5a, 4'b1010)}
      };

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_vectors[i])
         offer(directed_vectors[i].op,
               directed_vectors[i].typed ? directed_vectors[i].want
                                         : alu_outcome(directed_vectors[i].op));

      // Phase changes happen just after an accepting edge, before the receiver next looks at them
      // at a falling edge.
      for (int p = 0; p < PH_COUNT; p++) begin
         phase = traffic_phase_type'(p);
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            op_type op;
            op = random_op();
            offer(op, alu_outcome(op));
         end
      end
      @(negedge clock);
      req_ch.valid <= 1'b0;

      while (pending_outcomes.size() != 0) @(posedge clock);
      // Wait DRAIN_CYCLES more so that any spurious result still in the pipeline is caught.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("eight_bit_cpu_alu_with_bcd verification clean");
      else
         $display("eight_bit_cpu_alu_with_bcd verification failed");
      $finish;
   end

   // Result side: random stalls by phase, plus one long hold-off at the start of the backlog
   // phase, counted here so that the sender is unaffected by it.
   initial begin
      int held_cycles;
      held_cycles = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (phase == PH_BACKLOG && !backlog_held) begin
            rsp_ch.ready <= 1'b0;
            held_cycles++;
            if (held_cycles == BACKLOG_HOLD) backlog_held = 1'b1;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= RECEIVER_STALL_PCT[phase]);
         end
      end
   end

   // Each accepted result is matched against the oldest outstanding expectation.
   always @(posedge clock) begin : check_results
      res_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_outcomes.size() == 0) begin
            $error("result %0h arrived with no transaction outstanding", rsp_ch.result);
            mismatches++;
         end else begin
            want = pending_outcomes.pop_front();
            check_field("result",   want.result, rsp_ch.result);
            check_field("negative", {7'd0, want.flags.negative}, {7'd0, rsp_ch.negative});
            check_field("overflow", {7'd0, want.flags.overflow}, {7'd0, rsp_ch.overflow});
            check_field("zero",     {7'd0, want.flags.zero},     {7'd0, rsp_ch.zero});
            check_field("carry",    {7'd0, want.flags.carry},    {7'd0, rsp_ch.carry});
         end
      end
   end

   // Watchdog: the limit lies well beyond the slowest correct run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("eight_bit_cpu_alu_with_bcd verification failed");
         $finish;
      end
   end

endmodule
